// ===== design/pngunf_pkg.sv =====
`default_nettype none

package pngunf_pkg;

    typedef logic [7:0] byte_t;

    // Filter type codes of a row
    localparam byte_t FILT_NONE  = 8'd0;
    localparam byte_t FILT_SUB   = 8'd1;
    localparam byte_t FILT_UP    = 8'd2;
    localparam byte_t FILT_AVG   = 8'd3;
    localparam byte_t FILT_PAETH = 8'd4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_BPP     = 2'd0;
    localparam cfg_idx_t CFG_ROW_LEN = 2'd1;

    // Register widths and reset values
    localparam int unsigned BPP_W     = 3;
    localparam int unsigned ROW_LEN_W = 13;
    localparam int unsigned CFG_DATA_W = ROW_LEN_W;
    localparam logic [BPP_W-1:0]     BPP_RST     = 3'd4;
    localparam logic [BPP_W-1:0]     BPP_MAX     = 3'd4;
    localparam logic [ROW_LEN_W-1:0] ROW_LEN_RST = 13'd1024;

    // Depth of the left and upper-left histories
    localparam int unsigned HIST_DEPTH = 4;
    localparam int unsigned HIST_IDX_W = 2;

endpackage

`default_nettype wire

// ===== design/png_row_unfilter.sv =====
`default_nettype none

// PNG row reconstruction (unfilter), one byte per transaction. Each input
// transaction carries one filtered byte plus its row's filter type and a
// first-row flag in tuser; each output transaction carries the reconstructed
// byte, with tlast on the last byte of a row. Filter types 0..4 follow the
// PNG rules (none, sub, up, average, Paeth); any other type passes the byte.
// The previous row lives in a simple dual-port line store of MAX_ROW_BYTES
// bytes (one write, one read per cycle, registered read). Throughput is one
// byte per clock unless m_tready stalls the output. The line store is read
// and the byte captured in stage B at the accepting edge, then the predictor
// and adder settle into the output register. The left-neighbour recurrence
// closes through the predictor and left history, so back-to-back bytes need
// no stall even at one byte per pixel. A read of a column written in the
// same clock is served from a bypass register. The line store has no reset
// and no clearing pass: the first row of an image must be flagged first_row.
// Config writes (bytes_per_pixel, row_length) are taken at any time but must
// only be issued while the block is idle; out-of-range values are clamped.
module png_row_unfilter #(
    parameter int unsigned MAX_ROW_BYTES = 4096
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // input stream
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [7:0]                         s_tdata,   // [7:0] filtered_byte
    input  wire  [8:0]                         s_tuser,   // [7:0] filter_type, [8] first_row
    // result stream
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] recon_byte
    output logic                               m_tlast,   // row_end
    // configuration writes
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [pngunf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [pngunf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pngunf_pkg::*;

    // column address width and a compare width that covers both the column
    // count and the 13-bit row length
    localparam int unsigned CW = $clog2(MAX_ROW_BYTES);
    localparam int unsigned EW = (CW + 1 > ROW_LEN_W) ? CW + 1 : ROW_LEN_W;
    localparam logic [EW-1:0] MAX_LEN_E = EW'(MAX_ROW_BYTES);

    // ---------------- configuration ----------------
    logic [BPP_W-1:0]     bpp_reg;
    logic [ROW_LEN_W-1:0] row_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg     <= BPP_RST;
            row_len_reg <= ROW_LEN_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BPP:     bpp_reg     <= cfg_data[BPP_W-1:0];
                CFG_ROW_LEN: row_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamped pixel size and row length
    logic [BPP_W-1:0]      bpp_eff;
    logic [HIST_IDX_W-1:0] hist_idx;
    logic [EW-1:0]         len_eff;

    always_comb begin
        if (bpp_reg == '0)
            bpp_eff = BPP_W'(1);
        else if (bpp_reg > BPP_MAX)
            bpp_eff = BPP_MAX;
        else
            bpp_eff = bpp_reg;
        hist_idx = HIST_IDX_W'(bpp_eff - BPP_W'(1));

        if (row_len_reg == '0)
            len_eff = EW'(1);
        else if (EW'(row_len_reg) > MAX_LEN_E)
            len_eff = MAX_LEN_E;
        else
            len_eff = EW'(row_len_reg);
    end

    // ---------------- stage A: accept, column, line store read ----------------
    logic          b_valid_reg;
    logic          b_adv;
    logic          s_accept;
    logic [CW-1:0] column_count_reg;
    logic [CW-1:0] column_count_next;
    logic [CW-1:0] a_col;
    logic          a_last;
    logic          a_left_ok;
    logic [EW-1:0] col_e;

    assign s_tready = !b_valid_reg || b_adv;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        col_e = EW'(column_count_reg);
        // a shortened row ends at its new last column
        if (col_e >= len_eff)
            col_e = len_eff - EW'(1);
        a_col     = col_e[CW-1:0];
        a_last    = (col_e == len_eff - EW'(1));
        a_left_ok = (col_e >= EW'(bpp_eff));
        column_count_next = column_count_reg;
        if (s_accept)
            column_count_next = a_last ? '0 : a_col + CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            column_count_reg <= '0;
        else
            column_count_reg <= column_count_next;
    end

    // line store: previous reconstructed row
    byte_t         line_mem [MAX_ROW_BYTES];
    byte_t         rd_data_reg;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    byte_t         wr_data;
    logic          byp_reg;
    byte_t         byp_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en)
            line_mem[wr_addr] <= wr_data;
        if (s_accept)
            rd_data_reg <= line_mem[a_col];
    end

    // same-column write and read in the same clock (short rows): forward the write
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            byp_reg      <= wr_en && (wr_addr == a_col);
            byp_data_reg <= wr_data;
        end
    end

    // stage B payload
    byte_t         b_fb_reg;
    byte_t         b_ft_reg;
    logic          b_first_reg;
    logic [CW-1:0] b_col_reg;
    logic          b_left_ok_reg;
    logic          b_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            b_valid_reg <= 1'b0;
        else if (s_accept)
            b_valid_reg <= 1'b1;
        else if (b_adv)
            b_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            b_fb_reg      <= s_tdata;
            b_ft_reg      <= s_tuser[7:0];
            b_first_reg   <= s_tuser[8];
            b_col_reg     <= a_col;
            b_left_ok_reg <= a_left_ok;
            b_last_reg    <= a_last;
        end
    end

    // ---------------- stage B: predictor, reconstruction, write-back ----------------
    byte_t left_hist_reg [HIST_DEPTH];
    byte_t upl_hist_reg  [HIST_DEPTH];
    logic  m_valid_reg;
    byte_t m_data_reg;
    logic  m_last_reg;

    byte_t             nb_a, nb_b, nb_c, pred, recon;
    logic [8:0]        ab_sum;
    logic signed [9:0] d_ac, d_bc, d_abc;
    logic [9:0]        pa, pb, pc;

    assign b_adv = b_valid_reg && (!m_valid_reg || m_tready);

    always_comb begin
        nb_b = b_first_reg ? 8'd0 : (byp_reg ? byp_data_reg : rd_data_reg);
        nb_a = b_left_ok_reg ? left_hist_reg[hist_idx] : 8'd0;
        nb_c = b_left_ok_reg ? upl_hist_reg[hist_idx] : 8'd0;

        ab_sum = {1'b0, nb_a} + {1'b0, nb_b};

        // Paeth distances: pa = |b-c|, pb = |a-c|, pc = |a+b-2c|
        d_bc  = $signed({2'b00, nb_b}) - $signed({2'b00, nb_c});
        d_ac  = $signed({2'b00, nb_a}) - $signed({2'b00, nb_c});
        d_abc = d_ac + d_bc;
        pa = d_bc[9]  ? 10'(-d_bc)  : 10'(d_bc);
        pb = d_ac[9]  ? 10'(-d_ac)  : 10'(d_ac);
        pc = d_abc[9] ? 10'(-d_abc) : 10'(d_abc);

        case (b_ft_reg)
            FILT_SUB:   pred = nb_a;
            FILT_UP:    pred = nb_b;
            FILT_AVG:   pred = ab_sum[8:1];
            FILT_PAETH: begin
                if (pa <= pb && pa <= pc)
                    pred = nb_a;
                else if (pb <= pc)
                    pred = nb_b;
                else
                    pred = nb_c;
            end
            default:    pred = 8'd0;
        endcase
        recon = b_fb_reg + pred;

        wr_en   = b_adv;
        wr_addr = b_col_reg;
        wr_data = recon;
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            left_hist_reg[0] <= recon;
            upl_hist_reg[0]  <= nb_b;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                left_hist_reg[i] <= left_hist_reg[i-1];
                upl_hist_reg[i]  <= upl_hist_reg[i-1];
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (b_adv)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            m_data_reg <= recon;
            m_last_reg <= b_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> (EW'(column_count_next) < MAX_LEN_E))
        else $error("column count past line store depth");

    a_row_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && a_last) |=> (column_count_reg == '0))
        else $error("column count did not wrap after last byte");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && m_valid_reg && !m_tready) |-> !s_accept)
        else $error("input accepted while stage B is stalled");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_adv) |=> (b_valid_reg && $stable(b_col_reg)))
        else $error("stalled item lost in stage B");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !b_valid_reg))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
